// ===== design/pur_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pur_pkg: shared types and constants of the piecewise-linear resampler
// Sizes of the breakpoint store, field widths, request codes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package pur_pkg;

    localparam int BP_DEPTH   = 1024;
    localparam int PTR_W      = $clog2(BP_DEPTH);
    localparam int CNT_W      = $clog2(BP_DEPTH + 1);

    localparam int TIME_W     = 40;
    localparam int VAL_W      = 32;
    localparam int IDX_W      = 24;
    localparam int STEP_W     = 16;

    localparam int DIV_STEPS  = 32;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic REG_GRID_STEP   = 1'b0;
    localparam logic REG_NUM_SAMPLES = 1'b1;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_SAMPLE = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        RD_PTR   = 2'd0,
        RD_NEXT  = 2'd1,
        RD_NEXT2 = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    clear;
        logic    append;
        logic    start;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    ld_a;
        logic    walk;
        logic    setup;
        logic    mul_lo;
        logic    mul_hi;
        logic    sum;
        logic    div_step;
        logic    fin;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic no_next;
        logic hit;
        logic walk_end;
        logic hold;
    } t_stat;

endpackage

// ===== design/pwl_uniform_resampler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwl_uniform_resampler: piecewise-linear waveform resampler
// Stores breakpoints and returns linearly interpolated values on a uniform
// time grid, with a register port for the grid step and the sample count.
// ----------------------------------------------------------------------------
// Items arrive on the s_axis channel; tuser carries the request kind (clear,
// append breakpoint, sample). Clear and append change the stored state and give no
// result. A sample request gives one item on m_axis with the value, its grid
// index, tlast on the last grid index and the empty and overflow flags.
// With no breakpoints, a sample goes straight to its result. Otherwise the
// bracket search reads one stored breakpoint per cycle from a single memory
// port, and is skipped when the pointer already sits on the last breakpoint;
// a held value (outside or coincident points) is then ready, and an
// interpolated one passes through the two multiply halves, the sum, the 32
// steps of the bit-serial divider and the final add.
// A finished result waits in the output register while the receiver stalls;
// new items are taken meanwhile, and the next result waits until that
// register is free. Reset empties the table, zeroes the grid index and the
// bracket pointer, sets the grid step and the sample count to one and drops
// any pending result.
// ----------------------------------------------------------------------------
module pwl_uniform_resampler
    import pur_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [71:0]       s_axis_tdata,  // point_time[39:0], point_value[71:40]
    input  logic [1:0]        s_axis_tuser,  // req_type[1:0]

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [55:0]       m_axis_tdata,  // sample_value[31:0], sample_index[55:32]
    output logic              m_axis_tlast,
    output logic [1:0]        m_axis_tuser,  // no_data[0], overflowed[1]

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [STEP_W-1:0] r_grid_step;
    logic [IDX_W-1:0]  r_num_samples;
    logic              w_cfg_wr;
    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [VAL_W-1:0]  w_value;
    logic [IDX_W-1:0]  w_index;
    logic              w_last, w_nodata, w_ovf;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_step   <= STEP_W'(1);
            r_num_samples <= IDX_W'(1);
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_GRID_STEP:   r_grid_step   <= pwdata[STEP_W-1:0];
                REG_NUM_SAMPLES: r_num_samples <= pwdata[IDX_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_GRID_STEP:   prdata = {{(APB_DW - STEP_W){1'b0}}, r_grid_step};
            REG_NUM_SAMPLES: prdata = {{(APB_DW - IDX_W){1'b0}}, r_num_samples};
        endcase
    end

    pur_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_type   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    pur_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_grid_step   (r_grid_step),
        .i_num_samples (r_num_samples),
        .i_pt_time     (s_axis_tdata[39:0]),
        .i_pt_value    (s_axis_tdata[71:40]),
        .o_stat        (w_stat),
        .o_value       (w_value),
        .o_index       (w_index),
        .o_last        (w_last),
        .o_nodata      (w_nodata),
        .o_ovf         (w_ovf)
    );

    assign m_axis_tdata = {w_index, w_value};
    assign m_axis_tlast = w_last;
    assign m_axis_tuser = {w_ovf, w_nodata};

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register loaded while holding an untaken item");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.ld_a, w_cmd.walk, w_cmd.setup, w_cmd.mul_lo, w_cmd.mul_hi,
                  w_cmd.sum, w_cmd.div_step, w_cmd.fin, w_cmd.load_out, s_axis_tready}))
        else $error("more than one datapath step issued in a cycle");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.load_out))
        else $error("result valid raised without a result load");
`endif

endmodule

// ===== design/pur_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pur_ctrl: sequencer of the resampler
// Takes items, walks the bracket search, runs the multiply and the divide
// steps and hands each result to the output register.
// ----------------------------------------------------------------------------
module pur_ctrl
    import pur_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_type,
    input  logic       i_out_ready,
    input  t_stat      i_stat,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_RD_A   = 11'b000_0000_0010,
        S_LD_A   = 11'b000_0000_0100,
        S_WALK   = 11'b000_0000_1000,
        S_SETUP  = 11'b000_0001_0000,
        S_MUL_LO = 11'b000_0010_0000,
        S_MUL_HI = 11'b000_0100_0000,
        S_SUM    = 11'b000_1000_0000,
        S_DIV    = 11'b001_0000_0000,
        S_FIN    = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } t_state;

    t_state                 r_state, n_state;
    logic [DIV_CNT_W-1:0]   r_div_cnt, n_div_cnt;
    logic                   r_out_valid, n_out_valid;
    logic                   w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_type)
                        REQ_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        REQ_APPEND: begin
                            o_cmd.append = 1'b1;
                        end
                        REQ_SAMPLE: begin
                            o_cmd.start = 1'b1;
                            n_state = i_stat.empty ? S_DONE : S_RD_A;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD_A: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_PTR;
                n_state      = S_LD_A;
            end
            S_LD_A: begin
                o_cmd.ld_a   = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_NEXT;
                n_state      = i_stat.no_next ? S_SETUP : S_WALK;
            end
            S_WALK: begin
                o_cmd.walk   = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_NEXT2;
                if (i_stat.hit || i_stat.walk_end) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_stat.hold ? S_DONE : S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_MUL_HI;
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_div_cnt = DIV_CNT_W'(DIV_STEPS - 1);
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_div_cnt == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_div_cnt = r_div_cnt - 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/pur_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pur_datapath: breakpoint store and interpolation arithmetic
// Holds the breakpoint memories, counters, bracket registers, the shared
// multiplier, the bit-serial divider and the output register.
// ----------------------------------------------------------------------------
module pur_datapath
    import pur_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [STEP_W-1:0] i_grid_step,
    input  logic [IDX_W-1:0]  i_num_samples,
    input  logic [TIME_W-1:0] i_pt_time,
    input  logic [VAL_W-1:0]  i_pt_value,
    output t_stat             o_stat,
    output logic [VAL_W-1:0]  o_value,
    output logic [IDX_W-1:0]  o_index,
    output logic              o_last,
    output logic              o_nodata,
    output logic              o_ovf
);

    logic [TIME_W-1:0] r_bp_times  [BP_DEPTH];
    logic [VAL_W-1:0]  r_bp_values [BP_DEPTH];

    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  r_ptr;
    logic [IDX_W-1:0]  r_grid;
    logic              r_ovf;

    logic [IDX_W-1:0]  r_idx;
    logic              r_last;
    logic              r_nodata;
    logic [TIME_W-1:0] r_t;
    logic [TIME_W-1:0] r_rd_t;
    logic [VAL_W-1:0]  r_rd_v;
    logic [TIME_W-1:0] r_t0, r_t1;
    logic [VAL_W-1:0]  r_v0, r_v1;
    logic              r_neg;
    logic [VAL_W-1:0]  r_mag;
    logic [TIME_W-1:0] r_num, r_den;
    logic [51:0]       r_pp_lo, r_pp_hi;
    logic [TIME_W-1:0] r_rem;
    logic [VAL_W-1:0]  r_dvd;
    logic [VAL_W-1:0]  r_res;

    logic [VAL_W-1:0]  r_o_value;
    logic [IDX_W-1:0]  r_o_index;
    logic              r_o_last, r_o_nodata, r_o_ovf;

    logic [PTR_W-1:0]  w_rd_addr;
    logic [TIME_W-1:0] w_grid_time;
    logic [IDX_W-1:0]  w_last_idx;
    logic [IDX_W-1:0]  w_next_grid;
    logic [CNT_W-1:0]  w_ptr_p1;
    logic [CNT_W:0]    w_ptr_p2;
    logic              w_le0, w_ge1;
    logic [VAL_W:0]    w_dv;
    logic [VAL_W:0]    w_dv_abs;
    logic [19:0]       w_mul_b;
    logic [51:0]       w_mul_p;
    logic [71:0]       w_prod;
    logic [TIME_W:0]   w_shift;
    logic [TIME_W+1:0] w_trial;
    logic              w_qbit;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_PTR:   w_rd_addr = r_ptr;
            RD_NEXT:  w_rd_addr = r_ptr + 1'b1;
            RD_NEXT2: w_rd_addr = r_ptr + 2'd2;
            default:  w_rd_addr = r_ptr;
        endcase
    end

    assign w_grid_time = TIME_W'(r_grid) * TIME_W'(i_grid_step);
    assign w_last_idx  = i_num_samples - 1'b1;
    assign w_next_grid = r_last ? '0 : r_idx + 1'b1;
    assign w_ptr_p1    = {1'b0, r_ptr} + 1'b1;
    assign w_ptr_p2    = {2'b00, r_ptr} + 2'd2;

    assign w_le0    = (r_t <= r_t0);
    assign w_ge1    = (r_t >= r_t1);
    assign w_dv     = {r_v1[VAL_W-1], r_v1} - {r_v0[VAL_W-1], r_v0};
    assign w_dv_abs = w_dv[VAL_W] ? ((VAL_W + 1)'(0) - w_dv) : w_dv;

    assign w_mul_b  = i_cmd.mul_hi ? r_num[39:20] : r_num[19:0];
    assign w_mul_p  = 52'(r_mag) * 52'(w_mul_b);
    assign w_prod   = {20'b0, r_pp_lo} + {r_pp_hi, 20'b0};

    assign w_shift  = {r_rem, r_dvd[VAL_W-1]};
    assign w_trial  = {1'b0, w_shift} - {2'b00, r_den};
    assign w_qbit   = !w_trial[TIME_W+1];

    always_comb begin
        o_stat.empty    = (r_count == '0);
        o_stat.no_next  = (w_ptr_p1 >= r_count);
        o_stat.hit      = (r_t0 <= r_t) && (r_t <= r_rd_t);
        o_stat.walk_end = (w_ptr_p2 >= {1'b0, r_count});
        o_stat.hold     = w_le0 || w_ge1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.append && (r_count < CNT_W'(BP_DEPTH))) begin
            r_bp_times[r_count[PTR_W-1:0]]  <= i_pt_time;
            r_bp_values[r_count[PTR_W-1:0]] <= i_pt_value;
        end
        if (i_cmd.rd_en) begin
            r_rd_t <= r_bp_times[w_rd_addr];
            r_rd_v <= r_bp_values[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
            r_grid  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                r_ptr   <= '0;
                r_grid  <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.append) begin
                if (r_count < CNT_W'(BP_DEPTH)) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.start && (r_count != '0) && ({1'b0, r_ptr} >= r_count)) begin
                r_ptr <= PTR_W'(r_count - 1'b1);
            end
            if (i_cmd.walk && !o_stat.hit) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_grid <= w_next_grid;
                if (w_next_grid == '0) begin
                    r_ptr <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_idx    <= r_grid;
            r_last   <= (r_grid == w_last_idx);
            r_nodata <= (r_count == '0);
            r_t      <= w_grid_time;
            r_res    <= '0;
        end
        if (i_cmd.ld_a) begin
            r_t0 <= r_rd_t;
            r_v0 <= r_rd_v;
            r_t1 <= r_rd_t;
            r_v1 <= r_rd_v;
        end
        if (i_cmd.walk) begin
            r_t1 <= r_rd_t;
            r_v1 <= r_rd_v;
            if (!o_stat.hit) begin
                r_t0 <= r_rd_t;
                r_v0 <= r_rd_v;
            end
        end
        if (i_cmd.setup) begin
            if (w_le0) begin
                r_res <= r_v0;
            end else if (w_ge1) begin
                r_res <= r_v1;
            end
            r_neg <= w_dv[VAL_W];
            r_mag <= w_dv_abs[VAL_W-1:0];
            r_num <= r_t - r_t0;
            r_den <= r_t1 - r_t0;
        end
        if (i_cmd.mul_lo) begin
            r_pp_lo <= w_mul_p;
        end
        if (i_cmd.mul_hi) begin
            r_pp_hi <= w_mul_p;
        end
        if (i_cmd.sum) begin
            r_rem <= w_prod[71:32];
            r_dvd <= w_prod[31:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= w_qbit ? w_trial[TIME_W-1:0] : w_shift[TIME_W-1:0];
            r_dvd <= {r_dvd[VAL_W-2:0], w_qbit};
        end
        if (i_cmd.fin) begin
            r_res <= r_neg ? (r_v0 - r_dvd) : (r_v0 + r_dvd);
        end
        if (i_cmd.load_out) begin
            r_o_value  <= r_res;
            r_o_index  <= r_idx;
            r_o_last   <= r_last;
            r_o_nodata <= r_nodata;
            r_o_ovf    <= r_ovf;
        end
    end

    assign o_value  = r_o_value;
    assign o_index  = r_o_index;
    assign o_last   = r_o_last;
    assign o_nodata = r_o_nodata;
    assign o_ovf    = r_o_ovf;

endmodule
